// File: src/eee_pkg.sv
// ============================================================================
// eee_pkg - shared types and constants for the emulated EEPROM
// Command codes, result kinds, card offsets and the queue item format.
// ============================================================================
package eee_pkg;

    // command codes on the input channel
    localparam logic [2:0] CMD_RD_BYTE  = 3'd0;
    localparam logic [2:0] CMD_WR_BYTE  = 3'd1;
    localparam logic [2:0] CMD_UPD_BYTE = 3'd2;
    localparam logic [2:0] CMD_RD_WORD  = 3'd3;
    localparam logic [2:0] CMD_WR_WORD  = 3'd4;
    localparam logic [2:0] CMD_RD_DWORD = 3'd5;
    localparam logic [2:0] CMD_WR_DWORD = 3'd6;
    localparam logic [2:0] CMD_FRESH    = 3'd7;

    // result kinds
    localparam logic [1:0] KIND_READ = 2'd0;
    localparam logic [1:0] KIND_CARD = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic [7:0]  ERASED_BYTE = 8'hFF;
    localparam logic [17:0] CHK_OFS     = 18'd33;
    localparam logic [17:0] DATA_OFS    = 18'd34;

    typedef enum logic [1:0] {
        OP_READ,
        OP_WRITE,
        OP_UPDATE,
        OP_FRESH
    } op_t;

    // one classified request as it sits in the queue
    typedef struct packed {
        op_t         op;
        logic [1:0]  last_byte;   // byte count minus one
        logic [11:0] address;
        logic [31:0] value;
    } item_t;

    typedef struct packed {
        logic        persist;
        logic [16:0] slot_base;
    } cfg_t;

endpackage

// File: src/eee_front.sv
// ============================================================================
// eee_front - request intake for the emulated EEPROM
// Decodes each command into an operation and byte count and holds it in a
// two-entry queue until the back end takes it.
// ============================================================================
module eee_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           init_done,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [2:0]     cmd,
    input  logic [11:0]    address,
    input  logic [31:0]    value,
    output logic           q_valid,
    output eee_pkg::item_t q_item,
    input  logic           q_pop
);

    eee_pkg::item_t q_entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    eee_pkg::item_t decoded;
    logic           push;

    always_comb
    begin
        decoded.address   = address;
        decoded.value     = value;
        decoded.op        = eee_pkg::OP_FRESH;
        decoded.last_byte = 2'd0;
        case (cmd)
            eee_pkg::CMD_RD_BYTE:  decoded.op = eee_pkg::OP_READ;
            eee_pkg::CMD_WR_BYTE:  decoded.op = eee_pkg::OP_WRITE;
            eee_pkg::CMD_UPD_BYTE: decoded.op = eee_pkg::OP_UPDATE;
            eee_pkg::CMD_RD_WORD:
            begin
                decoded.op        = eee_pkg::OP_READ;
                decoded.last_byte = 2'd1;
            end
            eee_pkg::CMD_WR_WORD:
            begin
                decoded.op        = eee_pkg::OP_WRITE;
                decoded.last_byte = 2'd1;
            end
            eee_pkg::CMD_RD_DWORD:
            begin
                decoded.op        = eee_pkg::OP_READ;
                decoded.last_byte = 2'd3;
            end
            eee_pkg::CMD_WR_DWORD:
            begin
                decoded.op        = eee_pkg::OP_WRITE;
                decoded.last_byte = 2'd3;
            end
            default:               decoded.op = eee_pkg::OP_FRESH;
        endcase
    end

    assign in_ready = init_done && (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = q_entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_entry_reg[wr_ptr_reg] <= decoded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != 2'd0)
        else $error("queue popped while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count beyond depth");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count missed a push");
`endif

endmodule

// File: src/eee_back.sv
// ============================================================================
// eee_back - command sequencer for the emulated EEPROM
// Owns the cell memory and running checksum, walks each request byte by
// byte and drives the registered result channel.
// ============================================================================
module eee_back #(
    parameter int DATA_BYTES = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  eee_pkg::cfg_t  cfg,
    input  logic           q_valid,
    input  eee_pkg::item_t q_item,
    output logic           q_pop,
    output logic           init_done,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [1:0]     kind,
    output logic [31:0]    read_data,
    output logic [17:0]    card_address,
    output logic [17:0]    card_data,
    output logic           last
);

    localparam int              IDX_W     = $clog2(DATA_BYTES);
    localparam logic [12:0]     LIMIT     = 13'(DATA_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DATA_BYTES - 1);
    localparam logic [17:0]     SUM_RESET = 18'((DATA_BYTES * 255) % 262144);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_DATA,
        S_CHK,
        S_DONE
    } state_t;

    logic [7:0] cell_mem [DATA_BYTES];
    logic [7:0] rdata_reg;

    state_t          state_reg, state_next;
    eee_pkg::item_t  item_reg, item_next;
    logic [1:0]      byte_idx_reg, byte_idx_next;
    logic [31:0]     rd_acc_reg, rd_acc_next;
    logic [IDX_W-1:0] clr_idx_reg, clr_idx_next;
    logic            clr_fresh_reg, clr_fresh_next;
    logic            init_done_reg, init_done_next;
    logic [17:0]     sum_reg, sum_next;
    logic [7:0]      new_byte_reg, new_byte_next;
    logic [17:0]     card_addr_reg, card_addr_next;
    logic            out_valid_reg, out_valid_next;
    logic [1:0]      kind_reg, kind_next;
    logic [31:0]     read_data_reg, read_data_next;
    logic [17:0]     card_address_reg, card_address_next;
    logic [17:0]     card_data_reg, card_data_next;
    logic            last_reg, last_next;

    logic [12:0]     cur_addr, nxt_addr;
    logic            cur_in, nxt_in, first_in, final_byte, out_free;
    logic [1:0]      shift;
    logic [7:0]      wr_byte, eval_byte;
    logic            mem_we;
    logic [IDX_W-1:0] mem_widx;
    logic [7:0]      mem_wdata;

    assign cur_addr   = {1'b0, item_reg.address} + {11'b0, byte_idx_reg};
    assign nxt_addr   = cur_addr + 13'd1;
    assign cur_in     = cur_addr < LIMIT;
    assign nxt_in     = nxt_addr < LIMIT;
    assign first_in   = {1'b0, q_item.address} < LIMIT;
    assign final_byte = (byte_idx_reg == item_reg.last_byte) || !nxt_in;
    assign shift      = item_reg.last_byte - byte_idx_reg;
    assign wr_byte    = 8'(item_reg.value >> {shift, 3'b000});
    assign eval_byte  = cur_in ? rdata_reg : eee_pkg::ERASED_BYTE;
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next        = state_reg;
        item_next         = item_reg;
        byte_idx_next     = byte_idx_reg;
        rd_acc_next       = rd_acc_reg;
        clr_idx_next      = clr_idx_reg;
        clr_fresh_next    = clr_fresh_reg;
        init_done_next    = init_done_reg;
        sum_next          = sum_reg;
        new_byte_next     = new_byte_reg;
        card_addr_next    = card_addr_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        kind_next         = kind_reg;
        read_data_next    = read_data_reg;
        card_address_next = card_address_reg;
        card_data_next    = card_data_reg;
        last_next         = last_reg;
        q_pop             = 1'b0;
        mem_we            = 1'b0;
        mem_widx          = cur_addr[IDX_W-1:0];
        mem_wdata         = wr_byte;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_widx  = clr_idx_reg;
                mem_wdata = eee_pkg::ERASED_BYTE;
                if (clr_idx_reg == LAST_IDX)
                begin
                    clr_idx_next   = '0;
                    sum_next       = SUM_RESET;
                    init_done_next = 1'b1;
                    clr_fresh_next = 1'b0;
                    state_next     = clr_fresh_reg ? S_DONE : S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop         = 1'b1;
                    item_next     = q_item;
                    byte_idx_next = 2'd0;
                    rd_acc_next   = 32'd0;
                    case (q_item.op)
                        eee_pkg::OP_FRESH:
                        begin
                            clr_fresh_next = 1'b1;
                            state_next     = S_CLEAR;
                        end
                        eee_pkg::OP_READ:
                        begin
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = (cfg.persist && first_in) ? S_READ : S_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (item_reg.op == eee_pkg::OP_READ)
                begin
                    rd_acc_next = {rd_acc_reg[23:0], eval_byte};
                    if (byte_idx_reg == item_reg.last_byte)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        byte_idx_next = byte_idx_reg + 2'd1;
                        state_next    = S_READ;
                    end
                end
                else if (item_reg.op == eee_pkg::OP_UPDATE && eval_byte == wr_byte)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    // commit the byte and adjust the checksum by new minus old
                    mem_we         = 1'b1;
                    sum_next       = sum_reg - {10'b0, rdata_reg} + {10'b0, wr_byte};
                    new_byte_next  = wr_byte;
                    card_addr_next = {1'b0, cfg.slot_base} + eee_pkg::DATA_OFS
                                     + {5'b0, cur_addr};
                    state_next     = S_DATA;
                end
            end
            S_DATA:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    kind_next         = eee_pkg::KIND_CARD;
                    read_data_next    = 32'd0;
                    card_address_next = card_addr_reg;
                    card_data_next    = {10'b0, new_byte_reg};
                    last_next         = 1'b0;
                    state_next        = S_CHK;
                end
            end
            S_CHK:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    kind_next         = eee_pkg::KIND_CARD;
                    read_data_next    = 32'd0;
                    card_address_next = {1'b0, cfg.slot_base} + eee_pkg::CHK_OFS;
                    card_data_next    = sum_reg;
                    last_next         = final_byte;
                    if (final_byte)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        byte_idx_next = byte_idx_reg + 2'd1;
                        state_next    = S_READ;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    card_address_next = 18'd0;
                    card_data_next    = 18'd0;
                    last_next         = 1'b1;
                    if (item_reg.op == eee_pkg::OP_READ)
                    begin
                        kind_next      = eee_pkg::KIND_READ;
                        read_data_next = rd_acc_reg;
                    end
                    else
                    begin
                        kind_next      = eee_pkg::KIND_DONE;
                        read_data_next = 32'd0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_widx] <= mem_wdata;
        end
        rdata_reg <= cell_mem[cur_addr[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_idx_reg      <= '0;
            clr_fresh_reg    <= 1'b0;
            init_done_reg    <= 1'b0;
            sum_reg          <= SUM_RESET;
            out_valid_reg    <= 1'b0;
            item_reg         <= '0;
            byte_idx_reg     <= 2'd0;
            rd_acc_reg       <= 32'd0;
            new_byte_reg     <= 8'd0;
            card_addr_reg    <= 18'd0;
            kind_reg         <= eee_pkg::KIND_DONE;
            read_data_reg    <= 32'd0;
            card_address_reg <= 18'd0;
            card_data_reg    <= 18'd0;
            last_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_idx_reg      <= clr_idx_next;
            clr_fresh_reg    <= clr_fresh_next;
            init_done_reg    <= init_done_next;
            sum_reg          <= sum_next;
            out_valid_reg    <= out_valid_next;
            item_reg         <= item_next;
            byte_idx_reg     <= byte_idx_next;
            rd_acc_reg       <= rd_acc_next;
            new_byte_reg     <= new_byte_next;
            card_addr_reg    <= card_addr_next;
            kind_reg         <= kind_next;
            read_data_reg    <= read_data_next;
            card_address_reg <= card_address_next;
            card_data_reg    <= card_data_next;
            last_reg         <= last_next;
        end
    end

    assign init_done    = init_done_reg;
    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign read_data    = read_data_reg;
    assign card_address = card_address_reg;
    assign card_data    = card_data_reg;
    assign last         = last_reg;

`ifndef NO_ASSERTIONS
    a_clear_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !q_pop)
        else $error("request taken during clearing pass");
    a_card_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != eee_pkg::KIND_CARD)
        |-> (card_address_reg == 18'd0 && card_data_reg == 18'd0))
        else $error("card fields set on a non-card result");
    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != eee_pkg::KIND_READ) |-> read_data_reg == 32'd0)
        else $error("read data set on a non-read result");
    a_chk_after_data: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK) |-> ($past(state_reg) == S_DATA || $past(state_reg) == S_CHK))
        else $error("checksum write without preceding data write");
`endif

endmodule

// File: src/emulated_eeprom_with_checksum.sv
// ============================================================================
// emulated_eeprom_with_checksum - byte EEPROM emulation with running checksum
// Top level: configuration registers, request intake and command sequencer.
// ============================================================================
// Usage:
//   Requests enter on in_valid/in_ready with cmd, address and value. Each
//   request yields one or more results on out_valid/out_ready; last marks the
//   final result of a request. Reads return one kind-0 result; each byte
//   written emits a card data write and then a card checksum write; a write
//   or update that writes nothing, and every fresh, returns one kind-2 result.
//   Sequencing: requests run one at a time through the sequencer,
//   which reads each cell through the registered memory port. Each
//   written byte passes through read, evaluate, data result and checksum
//   result. Fresh sweeps the memory at one cell per cycle.
//   Reset: the memory is swept to 255 and in_ready stays low until the
//   sweep ends. APB writes are taken throughout.
//   Stalls: a two-entry request queue keeps intake going while the result
//   register waits; when out_ready is low the sequencer holds its place and
//   the queue fills, then in_ready drops.
// ============================================================================
module emulated_eeprom_with_checksum #(
    parameter int DATA_BYTES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [11:0] address,
    input  logic [31:0] value,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [31:0] read_data,
    output logic [17:0] card_address,
    output logic [17:0] card_data,
    output logic        last
);

    // register select is the word index, bit 2 of the byte address
    localparam logic REG_PERSIST = 1'b0;
    localparam logic REG_SLOT    = 1'b1;

    logic           persist_reg;
    logic [16:0]    slot_reg;
    logic           cfg_write;
    eee_pkg::cfg_t  cfg;

    logic           q_valid;
    eee_pkg::item_t q_item;
    logic           q_pop;
    logic           init_done;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // hold configuration; the user must write it only while the block is idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            persist_reg <= 1'b0;
            slot_reg    <= 17'd0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_PERSIST: persist_reg <= pwdata[0];
                REG_SLOT:    slot_reg    <= pwdata[16:0];
                default:     persist_reg <= persist_reg;
            endcase
        end
    end

    // return the selected register on reads
    always_comb
    begin
        case (paddr[2])
            REG_PERSIST: prdata = {31'd0, persist_reg};
            REG_SLOT:    prdata = {15'd0, slot_reg};
            default:     prdata = 32'd0;
        endcase
    end

    assign cfg.persist   = persist_reg;
    assign cfg.slot_base = slot_reg;

    // decode and queue requests
    eee_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .init_done (init_done),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .address   (address),
        .value     (value),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    // execute requests against the cell memory and checksum
    eee_back #(
        .DATA_BYTES (DATA_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .init_done    (init_done),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .read_data    (read_data),
        .card_address (card_address),
        .card_data    (card_data),
        .last         (last)
    );

endmodule
